>>> src/length_field_frame_splitter_macros.svh
// Assertion helpers for the length-field frame splitter.
// With SYNTH defined every macro expands to nothing.
`ifndef LENGTH_FIELD_FRAME_SPLITTER_MACROS_SVH
`define LENGTH_FIELD_FRAME_SPLITTER_MACROS_SVH

`ifndef SYNTH

// cond_a holds -> cond_c holds in the same cycle
`define LFFS_ASSERT_IMPLIES(label, clk, rst, cond_a, cond_c) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_c)) \
      else $error("lffs assertion failed");

// cond_a holds -> cond_c holds in the next cycle
`define LFFS_ASSERT_NEXT(label, clk, rst, cond_a, cond_c) \
   label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_c)) \
      else $error("lffs assertion failed");

// cond must never hold
`define LFFS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lffs assertion failed");

`else

`define LFFS_ASSERT_IMPLIES(label, clk, rst, cond_a, cond_c)
`define LFFS_ASSERT_NEXT(label, clk, rst, cond_a, cond_c)
`define LFFS_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> src/lffs_pkg.sv
`default_nettype none

package lffs_pkg;

   // width of the in-frame byte counter
   localparam int POSITION_BITS = 32;
   localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [POSITION_BITS:0]   taken_type;

   typedef enum logic [3:0] {
      FMT_S8    = 4'd0,
      FMT_U8    = 4'd1,
      FMT_S16LE = 4'd2,
      FMT_U16LE = 4'd3,
      FMT_U16BE = 4'd4,
      FMT_S32LE = 4'd5,
      FMT_U32LE = 4'd6,
      FMT_U32BE = 4'd7,
      FMT_S64LE = 4'd8,
      FMT_U64LE = 4'd9,
      FMT_U64BE = 4'd10
   } format_type;

   typedef enum logic [2:0] {
      ST_FRAME     = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_ZERO      = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_DROPPED   = 3'd4
   } status_type;

   // register indexes on the csr port
   localparam logic [1:0] REG_LENGTH_FORMAT = 2'd0;
   localparam logic [1:0] REG_FIELD_OFFSET  = 2'd1;
   localparam logic [1:0] REG_BODY_OFFSET   = 2'd2;
   localparam logic [1:0] REG_MAX_LENGTH    = 2'd3;

   localparam logic [3:0]  RESET_LENGTH_FORMAT = FMT_U32LE;
   localparam logic [15:0] RESET_FIELD_OFFSET  = 16'd0;
   localparam logic [15:0] RESET_BODY_OFFSET   = 16'd4;
   localparam logic [31:0] RESET_MAX_LENGTH    = 32'd2097152;

   typedef struct packed {
      status_type status;
      pos_type    total;
   } decide_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      status_type status;
   } rsp_item_type;

   // length field size in bytes; zero marks an invalid format
   function automatic logic [3:0] fmt_size(input logic [3:0] fmt);
      logic [3:0] size;
      case (fmt)
         FMT_S8, FMT_U8:                         size = 4'd1;
         FMT_S16LE, FMT_U16LE, FMT_U16BE:        size = 4'd2;
         FMT_S32LE, FMT_U32LE, FMT_U32BE:        size = 4'd4;
         FMT_S64LE, FMT_U64LE, FMT_U64BE:        size = 4'd8;
         default:                                size = 4'd0;
      endcase
      return size;
   endfunction

endpackage

`default_nettype wire

>>> src/lffs_length_decode.sv
`default_nettype none

module lffs_length_decode
   import lffs_pkg::*;
(
   input  wire logic [63:0] gather,
   input  wire logic [3:0]  length_format,
   input  wire logic [15:0] body_offset,
   input  wire logic [31:0] max_frame_length,
   input  wire taken_type   taken,
   output decide_type       decide
);

   logic [63:0] value;
   logic        negative;
   logic [32:0] total;
   logic        too_large;

   // byte lanes of the gathered field, first byte received in lane 0
   always_comb begin
      value    = 64'd0;
      negative = 1'b0;
      case (length_format)
         FMT_S8: begin
            value    = {56'd0, gather[7:0]};
            negative = gather[7];
         end
         FMT_U8:    value = {56'd0, gather[7:0]};
         FMT_S16LE: begin
            value    = {48'd0, gather[15:0]};
            negative = gather[15];
         end
         FMT_U16LE: value = {48'd0, gather[15:0]};
         FMT_U16BE: value = {48'd0, gather[7:0], gather[15:8]};
         FMT_S32LE: begin
            value    = {32'd0, gather[31:0]};
            negative = gather[31];
         end
         FMT_U32LE: value = {32'd0, gather[31:0]};
         FMT_U32BE: value = {32'd0, gather[7:0], gather[15:8], gather[23:16], gather[31:24]};
         FMT_S64LE: begin
            value    = gather;
            negative = gather[63];
         end
         FMT_U64LE: value = gather;
         FMT_U64BE: value = {gather[7:0], gather[15:8], gather[23:16], gather[31:24],
                             gather[39:32], gather[47:40], gather[55:48], gather[63:56]};
         default: begin
            value    = 64'd0;
            negative = 1'b0;
         end
      endcase
   end

   assign total     = {17'd0, body_offset} + {1'b0, value[31:0]};
   assign too_large = (|value[63:32])
                      || (total > {1'b0, max_frame_length})
                      || (64'(total) > POS_LIMIT);

   always_comb begin
      decide.total = pos_type'(total);
      if (negative) begin
         decide.status = ST_MALFORMED;
      end else if ((value == 64'd0) && (body_offset == 16'd0)) begin
         decide.status = ST_ZERO;
      end else if (too_large) begin
         decide.status = ST_TOO_LARGE;
      end else if (64'(total) < 64'(taken)) begin
         decide.status = ST_MALFORMED;
      end else begin
         decide.status = ST_FRAME;
      end
   end

endmodule

`default_nettype wire

>>> src/lffs_rsp_buffer.sv
`default_nettype none

module lffs_rsp_buffer
   import lffs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire rsp_item_type push_item,
   output logic        has_room,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output rsp_item_type rsp_item
);

   rsp_item_type entry0_ff, entry0_in;
   rsp_item_type entry1_ff, entry1_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop       = (count_ff != 2'd0) && rsp_ready;
   assign has_room  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = entry0_ff;

   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         if (count_ff == 2'd0) begin
            entry0_in = push_item;
         end else begin
            entry1_in = push_item;
         end
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         entry0_in = entry1_ff;
         count_in  = count_ff - 2'd1;
      end else if (push && pop) begin
         if (count_ff == 2'd1) begin
            entry0_in = push_item;
         end else begin
            entry0_in = entry1_ff;
            entry1_in = push_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

`include "length_field_frame_splitter_macros.svh"

   `LFFS_ASSERT_NEVER(a_no_push_when_full, clock, reset, push && (count_ff == 2'd2))
   `LFFS_ASSERT_NEVER(a_count_in_range, clock, reset, count_ff == 2'd3)
   `LFFS_ASSERT_NEXT(a_valid_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

`default_nettype wire

>>> src/length_field_frame_splitter.sv
`default_nettype none

// Length-field frame splitter.
// req_*: one received stream byte per item (tdata = data_byte).
// rsp_*: one item per input byte: tdata echoes the byte, tlast marks the byte
//   that completes a frame, tuser carries the status (0 frame byte, 1 bad
//   length or format, 2 zero length, 3 too large, 4 dropped after an error).
// csr_*: write-only registers, index 0 length format, 1 length field offset,
//   2 body offset, 3 maximum frame length. Write only while the block is idle.
// Throughput: one byte per clock while the output buffer has room. Each byte
//   is fully handled in the cycle it is taken (field gather, decode, 33-bit
//   adds and the compares) and its result sits in a two-entry output buffer
//   in the next cycle, where it raises rsp_tvalid.
// Stall: req_tready only depends on buffer occupancy; while rsp_tready is low
//   bytes are still taken until both entries are filled, then req_tready
//   drops until an entry frees.
// Reset (synchronous, active high): registers return to their defaults
//   (u32le, offset 0, body 4, max 2 MiB), the frame restarts at byte zero,
//   the error stop clears and the output buffer empties.
// After any error every byte is echoed with status dropped until reset.
module length_field_frame_splitter
   import lffs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] byte_out
   output logic             rsp_tlast,
   output logic [2:0]       rsp_tuser,   // [2:0] status
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // configuration
   logic [3:0]  length_format_ff;
   logic [15:0] field_offset_ff;
   logic [15:0] body_offset_ff;
   logic [31:0] max_length_ff;

   // frame state
   pos_type     frame_position_ff, frame_position_in;
   logic [63:0] gather_ff, gather_in;
   pos_type     frame_total_ff, frame_total_in;
   logic        total_known_ff, total_known_in;
   logic        stopped_ff, stopped_in;

   logic         accept;
   taken_type    taken;
   logic [3:0]   size;
   logic [16:0]  hdr_end;
   logic         hdr_bad;
   pos_type      field_rel;
   logic         in_field;
   logic [63:0]  gather_new;
   logic         reach;
   decide_type   decide;
   status_type   status_in;
   logic         last_in;
   logic         known_after;
   pos_type      total_after;
   rsp_item_type item_in;
   rsp_item_type rsp_item;
   logic         has_room;

   assign accept = req_tvalid && req_tready;
   assign req_tready = has_room;

   // header geometry under the current registers
   assign size      = fmt_size(length_format_ff);
   assign hdr_end   = {1'b0, field_offset_ff} + 17'(size);
   assign hdr_bad   = (size == 4'd0) || (64'(hdr_end) > POS_LIMIT);
   assign taken     = {1'b0, frame_position_ff} + taken_type'(1);
   assign field_rel = frame_position_ff - pos_type'(field_offset_ff);
   assign in_field  = (frame_position_ff >= pos_type'(field_offset_ff))
                      && (field_rel < pos_type'(size));
   assign reach     = (taken >= taken_type'(hdr_end));

   // drop the incoming byte into its lane of the length field
   always_comb begin
      gather_new = gather_ff;
      for (int k = 0; k < 8; k++) begin
         if (in_field && (field_rel[2:0] == 3'(k))) begin
            gather_new[8*k +: 8] = gather_ff[8*k +: 8] | req_tdata;
         end
      end
   end

   lffs_length_decode u_decode (
      .gather           (gather_new),
      .length_format    (length_format_ff),
      .body_offset      (body_offset_ff),
      .max_frame_length (max_length_ff),
      .taken            (taken),
      .decide           (decide)
   );

   always_comb begin
      frame_position_in = frame_position_ff;
      gather_in         = gather_ff;
      frame_total_in    = frame_total_ff;
      total_known_in    = total_known_ff;
      stopped_in        = stopped_ff;
      status_in         = ST_FRAME;
      last_in           = 1'b0;
      known_after       = total_known_ff;
      total_after       = frame_total_ff;

      if (stopped_ff) begin
         status_in = ST_DROPPED;
      end else begin
         if (!total_known_ff) begin
            if (hdr_bad) begin
               status_in = ST_MALFORMED;
            end else begin
               gather_in         = gather_new;
               frame_position_in = pos_type'(taken);
               if (reach) begin
                  status_in = decide.status;
                  if (decide.status == ST_FRAME) begin
                     known_after = 1'b1;
                     total_after = decide.total;
                  end
               end
            end
         end else begin
            frame_position_in = pos_type'(taken);
         end

         total_known_in = known_after;
         frame_total_in = total_after;

         if (status_in != ST_FRAME) begin
            stopped_in = 1'b1;
         end else if (known_after && (taken >= taken_type'(total_after))) begin
            // byte completes the frame: start the next one
            last_in           = 1'b1;
            frame_position_in = '0;
            gather_in         = 64'd0;
            frame_total_in    = '0;
            total_known_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_format_ff  <= RESET_LENGTH_FORMAT;
         field_offset_ff   <= RESET_FIELD_OFFSET;
         body_offset_ff    <= RESET_BODY_OFFSET;
         max_length_ff     <= RESET_MAX_LENGTH;
         frame_position_ff <= '0;
         gather_ff         <= 64'd0;
         frame_total_ff    <= '0;
         total_known_ff    <= 1'b0;
         stopped_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LENGTH_FORMAT: length_format_ff <= csr_wdata[3:0];
               REG_FIELD_OFFSET:  field_offset_ff  <= csr_wdata[15:0];
               REG_BODY_OFFSET:   body_offset_ff   <= csr_wdata[15:0];
               REG_MAX_LENGTH:    max_length_ff    <= csr_wdata;
               default:           max_length_ff    <= max_length_ff;
            endcase
         end
         if (accept) begin
            frame_position_ff <= frame_position_in;
            gather_ff         <= gather_in;
            frame_total_ff    <= frame_total_in;
            total_known_ff    <= total_known_in;
            stopped_ff        <= stopped_in;
         end
      end
   end

   assign item_in.data   = req_tdata;
   assign item_in.last   = last_in;
   assign item_in.status = status_in;

   lffs_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (item_in),
      .has_room  (has_room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = rsp_item.data;
   assign rsp_tlast = rsp_item.last;
   assign rsp_tuser = rsp_item.status;

`include "length_field_frame_splitter_macros.svh"

   `LFFS_ASSERT_IMPLIES(a_last_only_on_good, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == ST_FRAME)
   `LFFS_ASSERT_NEXT(a_stop_sticks, clock, reset, stopped_ff, stopped_ff)
   `LFFS_ASSERT_IMPLIES(a_pos_below_total, clock, reset, total_known_ff, frame_position_ff < frame_total_ff)
   `LFFS_ASSERT_NEXT(a_error_stops, clock, reset, accept && (status_in != ST_FRAME), stopped_ff)

endmodule

`default_nettype wire
